### rtl/core/ppte_pkg.sv
// Shared constants, types and arithmetic helpers of the trajectory evaluator.
`default_nettype none
package ppte_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int MAX_COEFFS   = 8;
   localparam int ROW_WORDS    = 3 * MAX_COEFFS;
   localparam int COEF_DEPTH   = MAX_SEGMENTS * ROW_WORDS;
   localparam int COEF_AW      = $clog2(COEF_DEPTH);
   localparam int SEG_W        = 4;
   localparam int CI_W         = 5;
   localparam int DATA_W       = 32;
   localparam int TIME_W       = 31;
   localparam int CSR_IW       = 1;
   localparam int CSR_DW       = 5;

   typedef enum logic [1:0] {
      CMD_WR_COEFF = 2'd0,
      CMD_WR_END   = 2'd1,
      CMD_EVAL     = 2'd2
   } cmd_type;

   localparam logic [CSR_IW-1:0] CSR_SEG_COUNT   = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_DERIV_ORDER = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              hit;
   } sat_type;

   // clamp a 49-bit two's complement value to 32 bits
   function automatic sat_type sat32(input logic [48:0] v);
      sat_type r;
      r.val = v[31:0];
      r.hit = 1'b0;
      if (!v[48] && (|v[47:31])) begin
         r.val = 32'h7FFF_FFFF;
         r.hit = 1'b1;
      end else if (v[48] && !(&v[47:31])) begin
         r.val = 32'h8000_0000;
         r.hit = 1'b1;
      end
      return r;
   endfunction

   // round half up, drop 16 fraction bits, add a Q16.16 term
   function automatic logic [48:0] rnd_add(input logic [63:0] prod, input logic [31:0] addend);
      logic [63:0] r;
      r = prod + 64'd32768;
      return {r[63], r[63:16]} + {{17{addend[31]}}, addend};
   endfunction

endpackage
`default_nettype wire

### rtl/core/ppte_req_if.sv
// Request channel: command, write fields and query time.
`default_nettype none
interface ppte_req_if;
   import ppte_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [SEG_W-1:0]  seg_index;
   logic [CI_W-1:0]   coeff_index;
   logic signed [DATA_W-1:0] write_value;
   logic [TIME_W-1:0] query_time;

   modport source (output valid, cmd, seg_index, coeff_index, write_value, query_time,
                   input ready);
   modport sink   (input valid, cmd, seg_index, coeff_index, write_value, query_time,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/ppte_rsp_if.sv
// Response channel: position, velocity and status of one evaluation.
`default_nettype none
interface ppte_rsp_if;
   import ppte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pos_x;
   logic signed [DATA_W-1:0] pos_y;
   logic signed [DATA_W-1:0] pos_z;
   logic signed [DATA_W-1:0] vel_x;
   logic signed [DATA_W-1:0] vel_y;
   logic signed [DATA_W-1:0] vel_z;
   logic [SEG_W-1:0]         segment_used;
   logic                     past_end;
   logic                     saturated;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, segment_used,
                   past_end, saturated, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, segment_used,
                   past_end, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/piecewise_poly_trajectory_eval.sv
// Top level: coefficient and end-time memories with a Horner sequencer.
//
//   channel   dir  handshake          contents
//   req_ch    in   valid/ready        cmd, seg_index, coeff_index, write_value, query_time
//   rsp_ch    out  valid/ready        pos/vel x,y,z, segment_used, past_end, saturated
//   csr_*     in   csr_we only        csr_index, csr_wdata (segment_count, derivative_order)
//
// Writes are taken in the idle state. An evaluate scans the end times, one end-memory read
// per SRD/SCMP pair, then runs each axis of P = 2*order coefficients through Horner steps
// in the MUL, ADDP and ADDV states on the single shared 32x32 multiplier; a new request is
// taken from the cycle in which the result shows on the response channel.
// Synchronous active-high reset; the memories hold no reset value.
// A finished result waits in the output register while writes are still taken.
`default_nettype none
module piecewise_poly_trajectory_eval (
   input  logic                         clock,
   input  logic                         reset,
   ppte_req_if.sink                     req_ch,
   ppte_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [ppte_pkg::CSR_IW-1:0]  csr_index,
   input  logic [ppte_pkg::CSR_DW-1:0]  csr_wdata
);
   import ppte_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SRD  = 10'b00_0000_0010,
      ST_SCMP = 10'b00_0000_0100,
      ST_TLOC = 10'b00_0000_1000,
      ST_LOAD = 10'b00_0001_0000,
      ST_HEAD = 10'b00_0010_0000,
      ST_MUL  = 10'b00_0100_0000,
      ST_ADDP = 10'b00_1000_0000,
      ST_ADDV = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0] seg_count_ff, seg_count_in;
   logic [2:0] deriv_ff, deriv_in;

   logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];
   logic signed [DATA_W-1:0] end_mem  [MAX_SEGMENTS];
   logic signed [DATA_W-1:0] coef_rd_ff;
   logic signed [DATA_W-1:0] end_rd_ff;

   logic [SEG_W-1:0]  idx_ff, idx_in;
   logic [SEG_W-1:0]  sel_ff, sel_in;
   logic              past_ff, past_in;
   logic              sat_ff, sat_in;
   logic [TIME_W-1:0] qt_ff, qt_in;
   logic signed [DATA_W:0]   tq_ff, tq_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] t_ff, t_in;
   logic [1:0]        axis_ff, axis_in;
   logic [COEF_AW-1:0] base_ff, base_in;
   logic [2:0]        j_ff, j_in;
   logic signed [DATA_W-1:0] pos_ff, pos_in;
   logic signed [DATA_W-1:0] vel_ff, vel_in;
   logic signed [DATA_W-1:0] jc_ff, jc_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DATA_W-1:0] pos_res_ff [3];
   logic signed [DATA_W-1:0] vel_res_ff [3];
   logic                     res_we;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;
   logic signed [DATA_W-1:0] out_pos_ff [3];
   logic signed [DATA_W-1:0] out_vel_ff [3];
   logic [SEG_W-1:0]         out_seg_ff;
   logic                     out_past_ff;
   logic                     out_sat_ff;

   logic               req_acc;
   logic               coef_we, coef_re, end_we, end_re;
   logic [COEF_AW-1:0] coef_waddr, coef_raddr;
   logic [SEG_W-1:0]   n_last;
   logic [2:0]         d_eff;
   logic [3:0]         p_eff;
   logic [2:0]         j_top;
   logic               found;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [35:0]       jmul;
   logic [33:0]              tdiff;
   sat_type                  s_t, s_jc, s_pos, s_vel;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign n_last = (seg_count_ff == 5'd0) ? 4'd0 :
                   (seg_count_ff > 5'(MAX_SEGMENTS)) ? 4'(MAX_SEGMENTS - 1) :
                   4'(seg_count_ff - 5'd1);
   assign d_eff  = (deriv_ff == 3'd0) ? 3'd1 :
                   (deriv_ff > 3'(MAX_COEFFS / 2)) ? 3'(MAX_COEFFS / 2) : deriv_ff;
   assign p_eff  = {d_eff, 1'b0};
   assign j_top  = 3'(p_eff - 4'd1);

   assign coef_we    = req_acc && (req_ch.cmd == CMD_WR_COEFF) &&
                       (req_ch.coeff_index < CI_W'(ROW_WORDS));
   assign coef_waddr = COEF_AW'({req_ch.seg_index, 4'b0000}) +
                       COEF_AW'({req_ch.seg_index, 3'b000}) + COEF_AW'(req_ch.coeff_index);
   assign end_we     = req_acc && (req_ch.cmd == CMD_WR_END);
   assign end_re     = (state_ff == ST_SRD);
   assign coef_raddr = base_ff + COEF_AW'(j_in);

   assign found = !end_rd_ff[DATA_W-1] && (qt_ff <= end_rd_ff[TIME_W-1:0]);
   assign tdiff = {tq_ff[DATA_W], tq_ff} - {{2{prev_ff[DATA_W-1]}}, prev_ff};
   assign s_t   = sat32({{15{tdiff[33]}}, tdiff});

   assign jmul  = $signed({1'b0, (state_ff == ST_HEAD) ? j_top : j_ff}) * coef_rd_ff;
   assign s_jc  = sat32({{13{jmul[35]}}, jmul});
   assign mul_a = (state_ff == ST_ADDP) ? vel_ff : pos_ff;
   assign s_pos = sat32(rnd_add(prod_ff, coef_rd_ff));
   assign s_vel = sat32(rnd_add(prod_ff, jc_ff));

   always_comb begin
      state_in     = state_ff;
      seg_count_in = seg_count_ff;
      deriv_in     = deriv_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      past_in      = past_ff;
      sat_in       = sat_ff;
      qt_in        = qt_ff;
      tq_in        = tq_ff;
      prev_in      = prev_ff;
      t_in         = t_ff;
      axis_in      = axis_ff;
      base_in      = base_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      jc_in        = jc_ff;
      prod_in      = prod_ff;
      coef_re      = 1'b0;
      res_we       = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SEG_COUNT:   seg_count_in = csr_wdata[4:0];
            CSR_DERIV_ORDER: deriv_in     = csr_wdata[2:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.cmd == CMD_EVAL)) begin
               qt_in    = req_ch.query_time;
               idx_in   = '0;
               prev_in  = '0;
               sat_in   = 1'b0;
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (found) begin
               sel_in   = idx_ff;
               past_in  = 1'b0;
               tq_in    = {2'b00, qt_ff};
               state_in = ST_TLOC;
            end else if (idx_ff == n_last) begin
               sel_in   = idx_ff;
               past_in  = 1'b1;
               tq_in    = {end_rd_ff[DATA_W-1], end_rd_ff};
               state_in = ST_TLOC;
            end else begin
               prev_in  = end_rd_ff;
               idx_in   = idx_ff + 4'd1;
               state_in = ST_SRD;
            end
         end
         ST_TLOC: begin
            t_in     = s_t.val;
            sat_in   = sat_ff | s_t.hit;
            base_in  = COEF_AW'({sel_ff, 4'b0000}) + COEF_AW'({sel_ff, 3'b000});
            axis_in  = 2'd0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            j_in     = j_top;
            coef_re  = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            pos_in   = coef_rd_ff;
            vel_in   = s_jc.val;
            sat_in   = sat_ff | s_jc.hit;
            j_in     = j_top - 3'd1;
            coef_re  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_a * t_ff;
            jc_in    = s_jc.val;
            sat_in   = sat_ff | s_jc.hit;
            state_in = ST_ADDP;
         end
         ST_ADDP: begin
            pos_in   = s_pos.val;
            sat_in   = sat_ff | s_pos.hit;
            prod_in  = mul_a * t_ff;
            state_in = ST_ADDV;
         end
         ST_ADDV: begin
            if (j_ff != 3'd0) begin
               vel_in   = s_vel.val;
               sat_in   = sat_ff | s_vel.hit;
               j_in     = j_ff - 3'd1;
               coef_re  = 1'b1;
               state_in = ST_MUL;
            end else begin
               res_we = 1'b1;
               if (axis_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  base_in  = base_ff + COEF_AW'(p_eff);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_count_ff <= 5'd1;
         deriv_ff     <= 3'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_count_ff <= seg_count_in;
         deriv_ff     <= deriv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sel_ff  <= sel_in;
      past_ff <= past_in;
      sat_ff  <= sat_in;
      qt_ff   <= qt_in;
      tq_ff   <= tq_in;
      prev_ff <= prev_in;
      t_ff    <= t_in;
      axis_ff <= axis_in;
      base_ff <= base_in;
      j_ff    <= j_in;
      pos_ff  <= pos_in;
      vel_ff  <= vel_in;
      jc_ff   <= jc_in;
      prod_ff <= prod_in;
      if (res_we) begin
         pos_res_ff[axis_ff] <= pos_ff;
         vel_res_ff[axis_ff] <= vel_ff;
      end
      if (rsp_load) begin
         out_pos_ff  <= pos_res_ff;
         out_vel_ff  <= vel_res_ff;
         out_seg_ff  <= sel_ff;
         out_past_ff <= past_ff;
         out_sat_ff  <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_ch.write_value;
      end
      if (coef_re) begin
         coef_rd_ff <= coef_mem[coef_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[req_ch.seg_index] <= req_ch.write_value;
      end
      if (end_re) begin
         end_rd_ff <= end_mem[idx_ff];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pos_x        = out_pos_ff[0];
   assign rsp_ch.pos_y        = out_pos_ff[1];
   assign rsp_ch.pos_z        = out_pos_ff[2];
   assign rsp_ch.vel_x        = out_vel_ff[0];
   assign rsp_ch.vel_y        = out_vel_ff[1];
   assign rsp_ch.vel_z        = out_vel_ff[2];
   assign rsp_ch.segment_used = out_seg_ff;
   assign rsp_ch.past_end     = out_past_ff;
   assign rsp_ch.saturated    = out_sat_ff;

endmodule
`default_nettype wire

### rtl/core/ppte_checker.sv
// Port-level checks of the trajectory evaluator, bound to the top level.
`default_nettype none
module ppte_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_cmd,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ppte_pkg::DATA_W-1:0] rsp_pos_x,
   input logic signed [ppte_pkg::DATA_W-1:0] rsp_vel_z,
   input logic [ppte_pkg::SEG_W-1:0]        rsp_segment_used,
   input logic                              rsp_saturated
);
   import ppte_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_vel_z) &&
                                  $stable(rsp_segment_used) && $stable(rsp_saturated))
      else $error("response dropped or changed while stalled");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_EVAL) |=> !req_ready)
      else $error("request taken while an evaluation is running");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without an evaluation");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_ppte_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_cmd          (req_ch.cmd),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pos_x        (rsp_ch.pos_x),
   .rsp_vel_z        (rsp_ch.vel_z),
   .rsp_segment_used (rsp_ch.segment_used),
   .rsp_saturated    (rsp_ch.saturated)
);
`default_nettype wire
